@@ design/greedy_threshold_assignment_unit_assert.svh @@
// Assertion shorthands for the greedy threshold assignment checker.
// Each expects clk and rst in the scope of the use.
`ifndef GREEDY_THRESHOLD_ASSIGNMENT_UNIT_ASSERT_SVH
`define GREEDY_THRESHOLD_ASSIGNMENT_UNIT_ASSERT_SVH

// Consequence in the same cycle.
`define GTA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gta_checker: property violated");

// Consequence in the following cycle.
`define GTA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gta_checker: property violated");

`endif

@@ design/gta_pkg.sv @@
`default_nettype none

package gta_pkg;

  localparam logic [1:0] REQ_LOAD_GROUP = 2'd0;
  localparam logic [1:0] REQ_LOAD_COST  = 2'd1;
  localparam logic [1:0] REQ_RUN        = 2'd2;

  localparam logic signed [15:0] COST_BLANK = 16'sd16384;
  localparam logic signed [15:0] THRESHOLD_RESET = 16'sd4096;

  localparam int COL_POS_W = 8;

  typedef logic [COL_POS_W-1:0] col_pos_t;

endpackage

`default_nettype wire

@@ design/greedy_threshold_assignment_unit.sv @@
`default_nettype none

// Greedy thresholded assignment of detections to tracks.
// Command channel: an item transfers on a rising edge with start high and busy low.
// req_type selects a group end load, a cost entry load or a run. Loads leave
// busy low, so loads can stream one per cycle.
// A run raises busy and emits one result per match, then a summary result with
// last set. Each result shows for one cycle under result_strobe; the receiver
// cannot stall, so nothing waits on it.
// A run works in steps: setup reads the last group end, sets ncol and clears the
// column blanking; per match a scan walks every cost entry of the ndet rows and
// ncol columns, then a bisection over the tracks, a lookup of the group bounds
// and the blanking of that group's columns follow; unless every detection has
// matched, a last scan finds no match, then comes the summary. A run with no
// detections or no tracks goes straight to the summary. Each result shows in the
// cycle after its state; busy is already low under the summary. The scan walks
// the single cost memory read port one entry per cycle.
// Config channel: cfg_data transfers on cfg_valid and cfg_ready; cfg_ready is high
// only while idle.
// Reset sets the threshold to 0.5 and clears control state; the cost and group
// end stores hold garbage until loaded. Column blanking state is cleared per run.
module greedy_threshold_assignment_unit
  import gta_pkg::*;
#(
  parameter int MAX_DETS   = 32,
  parameter int MAX_TRACKS = 32,
  parameter int MAX_COLS   = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [4:0]         row_index,
  input  logic [6:0]         column_index,
  input  logic [4:0]         track_slot,
  input  logic [6:0]         group_end,
  input  logic signed [15:0] cost_value,
  input  logic [5:0]         det_count,
  input  logic [5:0]         track_count,
  output logic               result_strobe,
  output logic               is_match,
  output logic [4:0]         matched_track,
  output logic [4:0]         matched_det,
  output logic [31:0]        unmatched_tracks,
  output logic [31:0]        unmatched_dets,
  output logic [5:0]         match_count,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  localparam int RW    = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DCW   = $clog2(MAX_DETS + 1);
  localparam int TCW   = $clog2(MAX_TRACKS + 1);
  localparam int DEPTH = MAX_DETS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_NCOL_RD  = 15'b000000000000010,
    S_NCOL_SET = 15'b000000000000100,
    S_CLR      = 15'b000000000001000,
    S_SCAN     = 15'b000000000010000,
    S_DRAIN    = 15'b000000000100000,
    S_DECIDE   = 15'b000000001000000,
    S_BS_RD    = 15'b000000010000000,
    S_BS_CMP   = 15'b000000100000000,
    S_GL       = 15'b000001000000000,
    S_GH       = 15'b000010000000000,
    S_BSET     = 15'b000100000000000,
    S_BLANK    = 15'b001000000000000,
    S_MATCH    = 15'b010000000000000,
    S_SUMMARY  = 15'b100000000000000
  } state_t;

  state_t state;

  logic signed [15:0] match_threshold;
  logic [DCW-1:0]     ndet;
  logic [TCW-1:0]     ntrk;
  col_pos_t           ncol;
  logic [RW-1:0]      row;
  col_pos_t           col;
  logic               s1_valid;
  logic [RW-1:0]      s1_row;
  col_pos_t           s1_col;
  logic signed [15:0] best;
  logic [RW-1:0]      best_row;
  col_pos_t           best_col;
  logic [TCW-1:0]     bs_lo;
  logic [TCW-1:0]     bs_hi;
  logic [TW-1:0]      trk;
  col_pos_t           lo_col;
  col_pos_t           hi_col;
  logic [MAX_TRACKS-1:0] track_taken;
  logic [MAX_DETS-1:0]   det_taken;
  logic [DCW-1:0]     pairs;

  logic signed [15:0] cost_mem [DEPTH];
  logic [6:0]         ge_mem [MAX_TRACKS];
  logic               colblk_mem [MAX_COLS];
  logic signed [15:0] cost_q;
  logic [6:0]         ge_q;
  logic               colblk_q;

  logic               accept;
  logic               cost_we;
  logic               ge_we;
  logic [AW-1:0]      cost_waddr;
  logic [AW-1:0]      cost_raddr;
  logic [TW-1:0]      ge_raddr;
  logic               colblk_we;
  logic               colblk_wdata;
  logic [TCW:0]       mid_sum;
  logic [TCW-1:0]     bs_mid;
  col_pos_t           ge_plus;
  col_pos_t           ncol_sat;
  logic [DCW-1:0]     ndet_sat;
  logic [TCW-1:0]     ntrk_sat;
  logic               cand_hit;
  logic [MAX_TRACKS-1:0] trk_mask;
  logic [MAX_DETS-1:0]   det_mask;
  logic               scan_row_end;
  logic               scan_col_end;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && (state == S_IDLE);

  assign cost_we = accept && (req_type == REQ_LOAD_COST) &&
                   (32'(row_index) < MAX_DETS) && (32'(column_index) < MAX_COLS);
  assign ge_we   = accept && (req_type == REQ_LOAD_GROUP) &&
                   (32'(track_slot) < MAX_TRACKS);

  assign cost_waddr = AW'(32'(row_index) * MAX_COLS + 32'(column_index));
  assign cost_raddr = AW'(32'(row) * MAX_COLS + 32'(col));

  assign mid_sum = {1'b0, bs_lo} + {1'b0, bs_hi};
  assign bs_mid  = mid_sum[TCW:1];

  assign ge_plus  = {1'b0, ge_q} + col_pos_t'(1);
  assign ncol_sat = (32'(ge_plus) > MAX_COLS) ? col_pos_t'(MAX_COLS) : ge_plus;
  assign ndet_sat = (32'(det_count) > MAX_DETS) ? DCW'(MAX_DETS) : DCW'(det_count);
  assign ntrk_sat = (32'(track_count) > MAX_TRACKS) ? TCW'(MAX_TRACKS) : TCW'(track_count);

  assign cand_hit = s1_valid && !det_taken[s1_row] && !colblk_q && (cost_q < best);

  assign scan_col_end = (32'(col) + 1 == 32'(ncol));
  assign scan_row_end = (32'(row) + 1 == 32'(ndet));

  always_comb begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      trk_mask[i] = (32'(i) < 32'(ntrk));
    end
    for (int i = 0; i < MAX_DETS; i++) begin
      det_mask[i] = (32'(i) < 32'(ndet));
    end
  end

  always_comb begin
    unique case (state)
      S_NCOL_RD: ge_raddr = TW'(ntrk - TCW'(1));
      S_BS_RD:   ge_raddr = TW'(bs_mid);
      S_GL:      ge_raddr = trk - TW'(1);
      S_GH:      ge_raddr = trk;
      default:   ge_raddr = '0;
    endcase
  end

  always_comb begin
    colblk_we    = 1'b0;
    colblk_wdata = 1'b0;
    if (state == S_CLR) begin
      colblk_we = 1'b1;
    end else if (state == S_BLANK && col < hi_col) begin
      colblk_we    = 1'b1;
      colblk_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_value;
    end
    cost_q <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk) begin
    if (ge_we) begin
      ge_mem[TW'(track_slot)] <= group_end;
    end
    ge_q <= ge_mem[ge_raddr];
  end

  always_ff @(posedge clk) begin
    if (colblk_we) begin
      colblk_mem[CW'(col)] <= colblk_wdata;
    end
    colblk_q <= colblk_mem[CW'(col)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      match_threshold <= THRESHOLD_RESET;
      track_taken     <= '0;
      det_taken       <= '0;
      pairs           <= '0;
      s1_valid        <= 1'b0;
      result_strobe   <= 1'b0;
    end else begin
      result_strobe <= (state == S_MATCH) || (state == S_SUMMARY);
      s1_valid      <= (state == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        match_threshold <= cfg_data;
      end
      if (cand_hit) begin
        best     <= cost_q;
        best_row <= s1_row;
        best_col <= s1_col;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req_type == REQ_RUN) begin
            ndet        <= ndet_sat;
            ntrk        <= ntrk_sat;
            track_taken <= '0;
            det_taken   <= '0;
            pairs       <= '0;
            if (ndet_sat == '0 || ntrk_sat == '0) begin
              state <= S_SUMMARY;
            end else begin
              state <= S_NCOL_RD;
            end
          end
        end
        S_NCOL_RD: begin
          state <= S_NCOL_SET;
        end
        S_NCOL_SET: begin
          ncol  <= ncol_sat;
          col   <= '0;
          state <= S_CLR;
        end
        S_CLR: begin
          if (scan_col_end) begin
            row   <= '0;
            col   <= '0;
            best  <= COST_BLANK;
            state <= S_SCAN;
          end else begin
            col <= col + col_pos_t'(1);
          end
        end
        S_SCAN: begin
          s1_row   <= row;
          s1_col   <= col;
          if (scan_col_end) begin
            col <= '0;
            if (scan_row_end) begin
              state <= S_DRAIN;
            end else begin
              row <= row + RW'(1);
            end
          end else begin
            col <= col + col_pos_t'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (best < COST_BLANK && best < match_threshold) begin
            bs_lo <= '0;
            bs_hi <= ntrk;
            state <= S_BS_RD;
          end else begin
            state <= S_SUMMARY;
          end
        end
        S_BS_RD: begin
          if (bs_lo < bs_hi) begin
            state <= S_BS_CMP;
          end else begin
            trk   <= (bs_lo >= ntrk) ? TW'(ntrk - TCW'(1)) : TW'(bs_lo);
            state <= S_GL;
          end
        end
        S_BS_CMP: begin
          if (32'(ge_q) < 32'(best_col)) begin
            bs_lo <= bs_mid + TCW'(1);
          end else begin
            bs_hi <= bs_mid;
          end
          state <= S_BS_RD;
        end
        S_GL: begin
          state <= S_GH;
        end
        S_GH: begin
          lo_col <= (trk == '0) ? '0 : ge_plus;
          state  <= S_BSET;
        end
        S_BSET: begin
          hi_col <= (ge_plus > ncol) ? ncol : ge_plus;
          col    <= lo_col;
          state  <= S_BLANK;
        end
        S_BLANK: begin
          if (col < hi_col) begin
            col <= col + col_pos_t'(1);
          end else begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          track_taken[trk]     <= 1'b1;
          det_taken[best_row]  <= 1'b1;
          pairs                <= pairs + DCW'(1);
          is_match             <= 1'b1;
          matched_track        <= 5'(trk);
          matched_det          <= 5'(best_row);
          unmatched_tracks     <= '0;
          unmatched_dets       <= '0;
          match_count          <= '0;
          last                 <= 1'b0;
          if (32'(pairs) + 1 == 32'(ndet)) begin
            state <= S_SUMMARY;
          end else begin
            row   <= '0;
            col   <= '0;
            best  <= COST_BLANK;
            state <= S_SCAN;
          end
        end
        S_SUMMARY: begin
          is_match         <= 1'b0;
          matched_track    <= '0;
          matched_det      <= '0;
          unmatched_tracks <= 32'(~track_taken & trk_mask);
          unmatched_dets   <= 32'(~det_taken & det_mask);
          match_count      <= 6'(pairs);
          last             <= 1'b1;
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/gta_checker.sv @@
`default_nettype none

`include "greedy_threshold_assignment_unit_assert.svh"

module gta_checker
  import gta_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       result_strobe,
  input logic       is_match,
  input logic       last
);

  logic load_accept;

  assign load_accept = start && !busy &&
                       (req_type == REQ_LOAD_GROUP || req_type == REQ_LOAD_COST);

  `GTA_ASSERT_NEXT(a_run_goes_busy, start && !busy && req_type == REQ_RUN, busy)
  `GTA_ASSERT_NEXT(a_load_stays_idle, load_accept, !busy)
  `GTA_ASSERT_NOW(a_last_marks_summary, result_strobe, last != is_match)
  `GTA_ASSERT_NOW(a_match_inside_run, result_strobe && is_match, busy)
  `GTA_ASSERT_NOW(a_summary_ends_run, result_strobe && last, !busy)

endmodule

bind greedy_threshold_assignment_unit gta_checker u_gta_checker (.*);

`default_nettype wire
